/* hw/rtl/fir_filter_mirror_extension_defines.svh */
// Assertion macros used by the verification file of the mirror-extension FIR.
// No dependencies; the include guard keeps a second inclusion harmless.
`ifndef FIR_FILTER_MIRROR_EXTENSION_DEFINES_SVH
`define FIR_FILTER_MIRROR_EXTENSION_DEFINES_SVH

// Same-cycle implication, disabled while dis is high.
`define FMX_ASSERT_IMPLY(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("fmx assertion failed");

// Next-cycle implication, disabled while dis is high.
`define FMX_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("fmx assertion failed");

`endif

/* hw/rtl/fmx_pkg.sv */
// Shared constants, types and the mirror operand selection of the FIR block.
// No dependencies; every RTL module imports this package.
`timescale 1ns / 1ps

package fmx_pkg;

    localparam int TAPS       = 7;
    localparam int HALF       = TAPS / 2;
    localparam int SAMPLE_W   = 16;
    localparam int COEFF_W    = 16;
    localparam int COEFF_FRAC = 14;
    localparam int NUM_COEFF  = 7;

    localparam int CFG_IDX_W  = $clog2(NUM_COEFF);
    localparam int CNT_W      = $clog2(TAPS + 1);
    localparam int K_W        = $clog2(HALF + 1);
    localparam int IDX_W      = $clog2(TAPS);
    localparam int OFF_W      = $clog2(2 * TAPS) + 1;
    localparam int PROD_W     = SAMPLE_W + COEFF_W;
    localparam int ACC_W      = PROD_W + $clog2(TAPS);
    localparam int DATA_W     = ((SAMPLE_W + 7) / 8) * 8;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEFF_W-1:0]  t_coeff;
    typedef t_sample [TAPS-1:0]         t_ops;
    typedef logic signed [ACC_W-1:0]    t_acc;

    typedef struct packed {
        logic last;
        logic too_short;
    } t_meta;

    // Operand m of an output is the window sample at distance |m - k| from the
    // output position, reflected about both ends of the received signal.
    // len_m1 is the window index of the oldest sample, k the drain offset.
    function automatic t_ops build_ops(t_ops win, logic [CNT_W-1:0] len_m1,
                                       logic [K_W-1:0] k);
        t_ops ops;
        logic signed [OFF_W-1:0] s;
        logic signed [OFF_W-1:0] d;
        logic signed [OFF_W-1:0] l;
        logic signed [OFF_W-1:0] kk;
        l  = $signed({{(OFF_W-CNT_W){1'b0}}, len_m1});
        kk = $signed({{(OFF_W-K_W){1'b0}}, k});
        for (int m = 0; m < TAPS; m++) begin
            s = OFF_W'(m) - kk;
            if (s < 0) begin
                d = -s;
            end else if (s > l) begin
                d = l + l - s;
            end else begin
                d = s;
            end
            ops[m] = win[d[IDX_W-1:0]];
        end
        return ops;
    endfunction

endpackage

/* hw/rtl/fmx_cell.sv */
// One multiply-accumulate cell of the systolic FIR chain.
// Depends on fmx_pkg for the sample, operand and accumulator types.
`timescale 1ns / 1ps

module fmx_cell
    import fmx_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_acc   i_acc,
    input  t_ops   i_ops,
    input  t_meta  i_meta,
    input  t_coeff i_coeff,
    output logic   o_valid,
    input  logic   i_ready,
    output t_acc   o_acc,
    output t_ops   o_ops,
    output t_meta  o_meta
);

    logic                     r_valid;
    t_acc                     r_acc;
    t_ops                     r_ops;
    t_meta                    r_meta;
    logic signed [PROD_W-1:0] w_prod;

    // Each cell consumes the lowest operand and hands the rest down the chain.
    assign w_prod  = $signed(i_ops[0]) * $signed(i_coeff);
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_acc  <= i_acc + ACC_W'(w_prod);
            r_ops  <= i_ops >> SAMPLE_W;
            r_meta <= i_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_ops   = r_ops;
    assign o_meta  = r_meta;

endmodule

/* hw/rtl/fmx_feed.sv */
// Front end: sample window, signal length count and the end-of-signal drain.
// Depends on fmx_pkg; issues one operand set per output word to the cell chain.
`timescale 1ns / 1ps

module fmx_feed
    import fmx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_sample i_sample,
    input  logic    i_last,
    output logic    o_valid,
    input  logic    i_ready,
    output t_ops    o_ops,
    output t_meta   o_meta
);

    t_ops             r_window, n_window;
    logic [CNT_W-1:0] r_count, n_count;
    logic [K_W-1:0]   r_drain_k, n_drain_k;
    logic [CNT_W-1:0] r_drain_len, n_drain_len;
    logic             r_valid, n_valid;
    t_ops             r_ops, n_ops;
    t_meta            r_meta, n_meta;

    logic             w_draining;
    logic             w_slot;
    logic             w_take;
    t_ops             w_shift;
    logic [CNT_W-1:0] w_count1;
    logic [CNT_W-1:0] w_len;

    assign w_draining = (r_drain_k != '0);
    assign w_slot     = !r_valid || i_ready;
    assign o_s_tready = w_slot && !w_draining;
    assign w_take     = i_s_tvalid && o_s_tready;
    assign w_shift    = {r_window[TAPS-2:0], i_sample};
    assign w_count1   = (r_count < CNT_W'(TAPS)) ? r_count + 1'b1 : r_count;
    assign w_len      = w_count1 - 1'b1;

    always_comb begin
        n_window    = r_window;
        n_count     = r_count;
        n_drain_k   = r_drain_k;
        n_drain_len = r_drain_len;
        n_valid     = r_valid;
        n_ops       = r_ops;
        n_meta      = r_meta;
        if (w_slot) begin
            n_valid = 1'b0;
        end
        if (w_draining && w_slot) begin
            // The window is frozen while the tail outputs of a signal go out.
            n_valid          = 1'b1;
            n_ops            = build_ops(r_window, r_drain_len, r_drain_k);
            n_meta.last      = (r_drain_k == K_W'(HALF));
            n_meta.too_short = 1'b0;
            n_drain_k        = (r_drain_k == K_W'(HALF)) ? '0 : r_drain_k + 1'b1;
        end else if (w_take) begin
            n_window = w_shift;
            if (w_count1 < CNT_W'(HALF + 1)) begin
                if (i_last) begin
                    n_valid          = 1'b1;
                    n_meta.last      = 1'b1;
                    n_meta.too_short = 1'b1;
                    n_count          = '0;
                end else begin
                    n_count = w_count1;
                end
            end else begin
                n_valid          = 1'b1;
                n_ops            = build_ops(w_shift, w_len, '0);
                n_meta.last      = 1'b0;
                n_meta.too_short = 1'b0;
                if (i_last) begin
                    n_drain_k   = K_W'(1);
                    n_drain_len = w_len;
                    n_count     = '0;
                end else begin
                    n_count = w_count1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_drain_k <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_drain_k <= n_drain_k;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_window    <= n_window;
        r_drain_len <= n_drain_len;
        r_ops       <= n_ops;
        r_meta      <= n_meta;
    end

    assign o_valid = r_valid;
    assign o_ops   = r_ops;
    assign o_meta  = r_meta;

endmodule

/* hw/rtl/fir_filter_mirror_extension.sv */
// Channel   Dir  Fields (low bit up)                    Accepted when
// s         in   tdata: sample; tlast: last_sample       i_s_tvalid && o_s_tready
// m         out  tdata: filtered; tlast: last_result;    o_m_tvalid && i_m_tready
//                tuser: too_short
// cfg       in   idx: coefficient number; data: coeff    i_cfg_we
//
// One sample word per cycle while o_s_tready is high; each word passes through the front end register,
// the seven multiply-accumulate cells and the output register.
// The last sample of a signal of four or more samples holds o_s_tready low
// while the front end sequencer issues the three tail outputs.
// Apart from the drain, each stage stalls only when its own register is full and not taken downstream.
// Synchronous active-low reset empties the pipe and zeroes the coefficients.
`timescale 1ns / 1ps

module fir_filter_mirror_extension
    import fmx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [DATA_W-1:0]    i_s_tdata,   // [15:0] sample
    input  logic                 i_s_tlast,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [DATA_W-1:0]    o_m_tdata,   // [15:0] filtered
    output logic                 o_m_tlast,
    output logic                 o_m_tuser,   // [0] too_short
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEFF_W-1:0]   i_cfg_data
);

    localparam t_acc ROUND   = t_acc'(1) <<< (COEFF_FRAC - 1);
    localparam t_acc SAT_MAX = (t_acc'(1) <<< (SAMPLE_W - 1)) - t_acc'(1);
    localparam t_acc SAT_MIN = -SAT_MAX - t_acc'(1);

    t_coeff  r_coeff [NUM_COEFF];

    logic    w_valid [TAPS+1];
    logic    w_ready [TAPS+1];
    t_acc    w_acc   [TAPS+1];
    t_ops    w_ops   [TAPS+1];
    t_meta   w_meta  [TAPS+1];

    t_acc    w_q;
    t_sample w_sat;

    logic    r_out_valid;
    t_sample r_filt;
    logic    r_last;
    logic    r_short;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_COEFF; c++) begin
                r_coeff[c] <= '0;
            end
        end else if (i_cfg_we && ({1'b0, i_cfg_idx} < (CFG_IDX_W + 1)'(NUM_COEFF))) begin
            r_coeff[i_cfg_idx] <= i_cfg_data;
        end
    end

    fmx_feed u_feed (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sample   (i_s_tdata[SAMPLE_W-1:0]),
        .i_last     (i_s_tlast),
        .o_valid    (w_valid[0]),
        .i_ready    (w_ready[0]),
        .o_ops      (w_ops[0]),
        .o_meta     (w_meta[0])
    );

    // The rounding offset enters with the first partial sum.
    assign w_acc[0] = ROUND;

    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        fmx_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_acc   (w_acc[g]),
            .i_ops   (w_ops[g]),
            .i_meta  (w_meta[g]),
            .i_coeff (r_coeff[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_acc   (w_acc[g+1]),
            .o_ops   (w_ops[g+1]),
            .o_meta  (w_meta[g+1])
        );
    end

    assign w_ready[TAPS] = !r_out_valid || i_m_tready;
    assign w_q           = w_acc[TAPS] >>> COEFF_FRAC;

    always_comb begin
        if (w_q > SAT_MAX) begin
            w_sat = SAT_MAX[SAMPLE_W-1:0];
        end else if (w_q < SAT_MIN) begin
            w_sat = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            w_sat = w_q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[TAPS]) begin
            r_out_valid <= w_valid[TAPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[TAPS] && w_valid[TAPS]) begin
            r_filt  <= w_meta[TAPS].too_short ? '0 : w_sat;
            r_last  <= w_meta[TAPS].last;
            r_short <= w_meta[TAPS].too_short;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = DATA_W'($unsigned(r_filt));
    assign o_m_tlast  = r_last;
    assign o_m_tuser  = r_short;

endmodule

/* hw/rtl/fmx_checker.sv */
// Port-level checks on the mirror-extension FIR, bound to the top level.
// Depends on fmx_pkg and the assertion macros of the defines header.
`timescale 1ns / 1ps
`include "fir_filter_mirror_extension_defines.svh"

module fmx_checker
    import fmx_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              i_s_tready,
    input logic              i_s_tlast,
    input logic              i_m_tvalid,
    input logic              i_m_tready,
    input logic [DATA_W-1:0] i_m_tdata,
    input logic              i_m_tlast,
    input logic              i_m_tuser
);

    // Samples seen so far in the current signal, held once it reaches HALF.
    logic [CNT_W-1:0] r_seen;
    logic             w_in_word;

    assign w_in_word = i_s_tvalid && i_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (w_in_word) begin
            if (i_s_tlast) begin
                r_seen <= '0;
            end else if (r_seen < CNT_W'(HALF)) begin
                r_seen <= r_seen + 1'b1;
            end
        end
    end

    `FMX_ASSERT_IMPLY(a_short_word, i_clk, !i_rst_n, i_m_tvalid && i_m_tuser, i_m_tlast && (i_m_tdata == '0))
    `FMX_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast) && $stable(i_m_tuser))
    `FMX_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !i_m_tvalid)
    `FMX_ASSERT_NEXT(a_drain_blocks, i_clk, !i_rst_n, w_in_word && i_s_tlast && (r_seen == CNT_W'(HALF)), !i_s_tready)

endmodule

bind fir_filter_mirror_extension fmx_checker u_fmx_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tlast  (o_m_tlast),
    .i_m_tuser  (o_m_tuser)
);
